// ===== hdl/smf_pkg.sv =====
// ----------------------------------------------------------------------------
// smf_pkg: shared types and constants of the sensor message framer
// Item modes, result status codes, fixed frame characters and the burst
// record that carries one item's bytes from the builder to the serializer.
// ----------------------------------------------------------------------------
package smf_pkg;

	// Item modes.
	localparam logic [1:0] MODE_BEGIN = 2'd0;
	localparam logic [1:0] MODE_ADD   = 2'd1;
	localparam logic [1:0] MODE_CLOSE = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NO_FRAME = 2'd2;

	// Fixed frame characters.
	localparam logic [7:0] CH_M = 8'h4D;
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_S = 8'h53;

	// Header length and the reserve kept free at the end of a frame.
	localparam int HDR_BYTES   = 16;
	localparam int ADD_BYTES   = 4;
	localparam int TAIL_MARGIN = 5;

	// Everything one item produces: up to sixteen result beats.
	typedef struct packed {
		logic                 present;   // item yields at least one beat
		logic [15:0][7:0]     bytes;     // bytes[0] goes out first
		logic [3:0]           last_idx;  // index of the final beat
		logic [1:0]           status;
		logic                 close;     // final beat ends the frame
	} burst_t;

endpackage

// ===== hdl/smf_build.sv =====
// ----------------------------------------------------------------------------
// smf_build: frame state and byte builder
// Holds the source address, message counter, frame length and running sum,
// and forms the complete byte burst of an item in one pass of logic.
// ----------------------------------------------------------------------------
module smf_build #(
	parameter int MAX_FRAME_BYTES = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [47:0]     cfg_data,
	input  logic            take,
	input  logic [1:0]      mode,
	input  logic [47:0]     dest_address,
	input  logic [15:0]     value_type,
	input  logic [15:0]     value_data,
	output smf_pkg::burst_t burst
);

	localparam int         LIMIT   = MAX_FRAME_BYTES - smf_pkg::TAIL_MARGIN;
	localparam logic [8:0] LIMIT_W = 9'(LIMIT);

	logic [47:0] own_address_q;
	logic [10:0] own_sum_q;
	logic [15:0] msg_counter_q;
	logic [7:0]  frame_length_q;
	logic [15:0] byte_sum_q;
	logic        frame_open_q;

	logic [15:0] msg_counter_d;
	logic [7:0]  frame_length_d;
	logic [15:0] byte_sum_d;
	logic        frame_open_d;

	logic [10:0] cfg_sum;
	logic [10:0] dest_sum;
	logic [15:0] begin_sum;
	logic [15:0] add_sum;
	logic        full;

	// Byte sum of a new source address, kept so that a header needs fewer adders.
	always_comb begin
		cfg_sum = '0;
		for (int i = 0; i < 6; i++) begin
			cfg_sum = cfg_sum + 11'(cfg_data[8*i +: 8]);
		end
	end

	always_comb begin
		dest_sum = '0;
		for (int i = 0; i < 6; i++) begin
			dest_sum = dest_sum + 11'(dest_address[8*i +: 8]);
		end
	end

	assign begin_sum = 16'(dest_sum) + 16'(own_sum_q) + 16'(smf_pkg::CH_M)
		+ 16'(smf_pkg::CH_I) + 16'(msg_counter_q[15:8]) + 16'(msg_counter_q[7:0]);

	assign add_sum = byte_sum_q + 16'(value_type[15:8]) + 16'(value_type[7:0])
		+ 16'(value_data[15:8]) + 16'(value_data[7:0]);

	assign full = ({1'b0, frame_length_q} + 9'(smf_pkg::ADD_BYTES)) > LIMIT_W;

	always_comb begin
		burst          = '0;
		msg_counter_d  = msg_counter_q;
		frame_length_d = frame_length_q;
		byte_sum_d     = byte_sum_q;
		frame_open_d   = frame_open_q;
		case (mode)
			smf_pkg::MODE_BEGIN: begin
				burst.present = 1'b1;
				for (int i = 0; i < 6; i++) begin
					burst.bytes[i]     = dest_address[40-8*i +: 8];
					burst.bytes[6 + i] = own_address_q[40-8*i +: 8];
				end
				burst.bytes[12] = smf_pkg::CH_M;
				burst.bytes[13] = smf_pkg::CH_I;
				burst.bytes[14] = msg_counter_q[15:8];
				burst.bytes[15] = msg_counter_q[7:0];
				burst.last_idx  = 4'(smf_pkg::HDR_BYTES - 1);
				burst.status    = smf_pkg::ST_OK;
				msg_counter_d   = msg_counter_q + 16'd1;
				frame_length_d  = 8'(smf_pkg::HDR_BYTES);
				byte_sum_d      = begin_sum;
				frame_open_d    = 1'b1;
			end
			smf_pkg::MODE_ADD: begin
				burst.present = 1'b1;
				if (!frame_open_q) begin
					burst.status = smf_pkg::ST_NO_FRAME;
				end else if (full) begin
					burst.status = smf_pkg::ST_FULL;
				end else begin
					burst.bytes[0] = value_type[15:8];
					burst.bytes[1] = value_type[7:0];
					burst.bytes[2] = value_data[15:8];
					burst.bytes[3] = value_data[7:0];
					burst.last_idx = 4'(smf_pkg::ADD_BYTES - 1);
					burst.status   = smf_pkg::ST_OK;
					frame_length_d = frame_length_q + 8'(smf_pkg::ADD_BYTES);
					byte_sum_d     = add_sum;
				end
			end
			smf_pkg::MODE_CLOSE: begin
				burst.present = 1'b1;
				if (!frame_open_q) begin
					burst.status = smf_pkg::ST_NO_FRAME;
				end else begin
					burst.bytes[0] = smf_pkg::CH_C;
					burst.bytes[1] = smf_pkg::CH_S;
					burst.bytes[2] = byte_sum_q[15:8];
					burst.bytes[3] = byte_sum_q[7:0];
					burst.last_idx = 4'(smf_pkg::ADD_BYTES - 1);
					burst.status   = smf_pkg::ST_OK;
					burst.close    = 1'b1;
					frame_length_d = '0;
					byte_sum_d     = '0;
					frame_open_d   = 1'b0;
				end
			end
			default: begin
				burst.present = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= '0;
			own_sum_q     <= '0;
		end else if (cfg_we) begin
			own_address_q <= cfg_data;
			own_sum_q     <= cfg_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_counter_q  <= '0;
			frame_length_q <= '0;
			byte_sum_q     <= '0;
			frame_open_q   <= 1'b0;
		end else if (take) begin
			msg_counter_q  <= msg_counter_d;
			frame_length_q <= frame_length_d;
			byte_sum_q     <= byte_sum_d;
			frame_open_q   <= frame_open_d;
		end
	end

endmodule

// ===== hdl/smf_serial.sv =====
// ----------------------------------------------------------------------------
// smf_serial: burst register and result serializer
// Holds one item's burst and hands its bytes to the result register one beat
// per cycle unless stalled, taking the next burst as the current one finishes.
// ----------------------------------------------------------------------------
module smf_serial (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  smf_pkg::burst_t burst,
	output logic            accept_ok,
	output logic            result_valid,
	input  logic            result_ready,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic [1:0]      status,
	output logic            last,
	output logic            frame_end
);

	smf_pkg::burst_t burst_s1;
	logic            burst_valid_s1;
	logic [3:0]      idx_q;
	logic            out_load;
	logic            beat_last;

	assign out_load  = burst_valid_s1 && (!result_valid || result_ready);
	assign beat_last = (idx_q == burst_s1.last_idx);
	assign accept_ok = !burst_valid_s1 || (out_load && beat_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_valid_s1 <= 1'b0;
			idx_q          <= '0;
		end else if (load) begin
			burst_valid_s1 <= 1'b1;
			idx_q          <= '0;
		end else if (out_load && beat_last) begin
			burst_valid_s1 <= 1'b0;
		end else if (out_load) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			burst_s1 <= burst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_load) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_byte   <= burst_s1.bytes[idx_q];
			byte_valid <= (burst_s1.status == smf_pkg::ST_OK);
			status     <= burst_s1.status;
			last       <= beat_last;
			frame_end  <= burst_s1.close && beat_last;
		end
	end

`ifndef SYNTH
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_end |-> last && byte_valid)
		else $error("frame end on a beat that is not a final byte");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !byte_valid |-> last && status != smf_pkg::ST_OK)
		else $error("error result is not a single final beat");

	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !last |=> result_valid)
		else $error("gap inside a burst");

	a_err_len: assert property (@(posedge clk) disable iff (!arst_n)
		burst_valid_s1 && burst_s1.status != smf_pkg::ST_OK |-> burst_s1.last_idx == 4'd0)
		else $error("error burst longer than one beat");
`endif

endmodule

// ===== hdl/sensor_message_framer.sv =====
// ----------------------------------------------------------------------------
// sensor_message_framer: outgoing sensor frame builder
// Turns begin, add and close items into a byte stream with header,
// port values and a closing checksum.
// ----------------------------------------------------------------------------
// Usage. Items arrive on the item channel (item_valid / item_ready) with
// fields mode, dest_address, value_type and value_data. Each item yields a
// burst of result beats on the result channel (result_valid / result_ready):
// sixteen beats for a begin, four for an accepted add or close, a single
// error beat for a rejected add or an add or close with no open frame, and
// none for the unused mode. The source address is written through the
// configuration channel (cfg_valid / cfg_ready / cfg_data), always ready.
// The first beat of an item passes through the burst register and then
// the result register. Throughput: one beat per cycle while the receiver
// is ready; the burst register and its beat index set this.
// The next item is taken in the cycle that the final beat of the current
// burst moves into the result register, so bursts follow without a gap.
// When the receiver stalls, the result register holds its beat and the
// burst register holds the rest; item_ready stays low until the burst drains.
// Reset clears the counter, the frame state, the source address and the
// burst and result valid flags.
// ----------------------------------------------------------------------------
module sensor_message_framer #(
	parameter int MAX_FRAME_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [47:0] cfg_data,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  mode,
	input  logic [47:0] dest_address,
	input  logic [15:0] value_type,
	input  logic [15:0] value_data,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic [1:0]  status,
	output logic        last,
	output logic        frame_end
);

	smf_pkg::burst_t burst;
	logic            take;
	logic            accept_ok;

	// Configuration is a single register, written on any handshake beat.
	assign cfg_ready = 1'b1;

	// An item is taken whenever the burst register is free or finishing.
	assign item_ready = accept_ok;
	assign take       = item_valid && accept_ok;

	// The builder updates the frame state and forms the whole burst in the
	// cycle the item is taken.
	smf_build #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_build (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid),
		.cfg_data    (cfg_data),
		.take        (take),
		.mode        (mode),
		.dest_address(dest_address),
		.value_type  (value_type),
		.value_data  (value_data),
		.burst       (burst)
	);

	// The serializer parks the burst and feeds the result register.
	// Items of the unused mode are taken but load nothing.
	smf_serial u_serial (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (take && burst.present),
		.burst       (burst),
		.accept_ok   (accept_ok),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.status      (status),
		.last        (last),
		.frame_end   (frame_end)
	);

endmodule
